// ===== hdl/hcda_pkg.sv =====
// Shared types, constants and calendar helpers for the hour-to-date advancer.
// No dependencies; imported by hdl/hour_to_calendar_date_advancer_core.sv.
package hcda_pkg;

  localparam int unsigned HoursW = 16;
  localparam int unsigned HpdW   = 12;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CntW   = 17;  // hour sum and whole-day count
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;

  localparam logic [YearW-1:0] MaxYear = YearW'(9999);
  localparam logic [MonW-1:0]  MonDec  = MonW'(12);
  localparam logic [DayW-1:0]  DayLast = DayW'(31);

  // 2^19 / 100, rounded up; exact quotient for any 14-bit year
  localparam logic [12:0] Recip100 = 13'd5243;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOURS_PER_DAY = 2'd0,
    CFG_START_DAY     = 2'd1,
    CFG_START_MONTH   = 2'd2,
    CFG_START_YEAR    = 2'd3
  } hcda_cfg_e;

  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_ADVANCE = 1'b1
  } hcda_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEAP_MUL,
    ST_LEAP_CHK,
    ST_FIX,
    ST_STEP,
    ST_DONE
  } hcda_state_e;

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    begin
      case (m)
        4'd2:                      len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

// ===== hdl/hour_to_calendar_date_advancer_core.sv =====
// Hour-to-calendar-date advancer: divider, leap check and month stepper in one core.
// Depends on hdl/hcda_pkg.sv.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  in       | in_valid_i / in_ready_o   | opcode_i, hours_i
//  out      | out_valid_o / out_ready_i | day_o, month_o, year_o, hour_remainder_o,
//           |                           | days_added_o, overflow_o
//  cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// Advance: restoring division of the hour sum by the day length, then the month stepper
// walks off the whole days, recomputing leap per year crossed. Restart: leap recompute,
// then overlong start-day fix-up. One shared 17-bit subtractor serves both loops.
// A beat is taken only in IDLE; a finished result waits in the output register and the
// next beat may be worked on meanwhile, stalling at its end until the register frees.
// Reset date is 01.01.2000 with a 24-hour day.
module hour_to_calendar_date_advancer_core
  import hcda_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [HoursW-1:0]   hours_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DayW-1:0]     day_o,
  output logic [MonW-1:0]     month_o,
  output logic [YearW-1:0]    year_o,
  output logic [HpdW-1:0]     hour_remainder_o,
  output logic [HoursW-1:0]   days_added_o,
  output logic                overflow_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [HpdW-1:0]  hpd_q;
  logic [DayW-1:0]  sday_q;
  logic [MonW-1:0]  smon_q;
  logic [YearW-1:0] syear_q;

  // calendar state
  hcda_state_e      state_q, state_d;
  logic [DayW-1:0]  day_q, day_d;
  logic [MonW-1:0]  mon_q, mon_d;
  logic [YearW-1:0] year_q, year_d;
  logic [HpdW-1:0]  acc_q, acc_d;
  logic             leap_q, leap_d;

  // working registers
  logic [CntW-1:0]   n_q, n_d;       // dividend/quotient during division, days left after
  logic [HpdW-1:0]   rem_q, rem_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [7:0]        q100_q, q100_d;
  logic              restart_q, restart_d;
  logic              ovf_q, ovf_d;
  logic [HoursW-1:0] days_q, days_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DayW-1:0]   out_day_q;
  logic [MonW-1:0]   out_mon_q;
  logic [YearW-1:0]  out_year_q;
  logic [HpdW-1:0]   out_rem_q;
  logic [HoursW-1:0] out_days_q;
  logic              out_ovf_q;
  logic              out_load;

  // shared subtractor
  logic [CntW-1:0] sub_a, sub_b;
  logic [CntW:0]   sub_diff;
  logic            sub_borrow;

  logic [HpdW-1:0]  divisor;
  logic [HpdW:0]    rem_shift;
  logic [HpdW-1:0]  rem_next;
  logic [CntW-1:0]  n_next;
  logic [DayW-1:0]  len;
  logic [DayW-1:0]  left;
  logic [26:0]      yprod;
  logic [YearW-1:0] q100_x100;
  logic [DayW-1:0]  norm_day;
  logic [MonW-1:0]  norm_mon;
  logic [YearW-1:0] norm_year;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpd_q   <= HpdW'(24);
      sday_q  <= DayW'(1);
      smon_q  <= MonW'(1);
      syear_q <= YearW'(2000);
    end else if (cfg_valid_i) begin
      case (hcda_cfg_e'(cfg_index_i))
        CFG_HOURS_PER_DAY: hpd_q   <= cfg_data_i[HpdW-1:0];
        CFG_START_DAY:     sday_q  <= cfg_data_i[DayW-1:0];
        CFG_START_MONTH:   smon_q  <= cfg_data_i[MonW-1:0];
        CFG_START_YEAR:    syear_q <= cfg_data_i[YearW-1:0];
        default: ;
      endcase
    end
  end

  assign divisor   = (hpd_q == '0) ? HpdW'(1) : hpd_q;
  assign norm_day  = (sday_q == '0) ? DayW'(1) : sday_q;
  assign norm_mon  = (smon_q == '0) ? MonW'(1) : ((smon_q > MonDec) ? MonDec : smon_q);
  assign norm_year = (syear_q == '0) ? YearW'(1) : syear_q;

  assign len  = month_len(mon_q, leap_q);
  assign left = (day_q < len) ? (len - day_q) : '0;

  assign rem_shift = {rem_q, n_q[CntW-1]};

  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = CntW'(rem_shift);
      sub_b = CntW'(divisor);
    end else begin
      sub_a = n_q;
      sub_b = CntW'(left) + CntW'(1);
    end
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[CntW];

  assign rem_next = sub_borrow ? rem_shift[HpdW-1:0] : sub_diff[HpdW-1:0];
  assign n_next   = {n_q[CntW-2:0], ~sub_borrow};

  // year / 100 by reciprocal; the times-100 is shifts and adds
  assign yprod     = year_q * Recip100;
  assign q100_x100 = YearW'({q100_q, 6'b0}) + YearW'({q100_q, 5'b0}) + YearW'({q100_q, 2'b0});

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    day_d       = day_q;
    mon_d       = mon_q;
    year_d      = year_q;
    acc_d       = acc_q;
    leap_d      = leap_q;
    n_d         = n_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    q100_d      = q100_q;
    restart_d   = restart_q;
    ovf_d       = ovf_q;
    days_d      = days_q;
    out_valid_d = out_valid_q;
    in_ready_o  = (state_q == ST_IDLE);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ovf_d  = 1'b0;
          days_d = '0;
          if (hcda_op_e'(opcode_i) == OP_ADVANCE) begin
            n_d     = CntW'(acc_q) + CntW'(hours_i);
            rem_d   = '0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end else begin
            acc_d = '0;
            if (norm_year > MaxYear) begin
              day_d   = DayLast;
              mon_d   = MonDec;
              year_d  = MaxYear;
              leap_d  = 1'b0;
              ovf_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              day_d     = norm_day;
              mon_d     = norm_mon;
              year_d    = norm_year;
              n_d       = '0;
              restart_d = 1'b1;
              state_d   = ST_LEAP_MUL;
            end
          end
        end
      end

      ST_DIV: begin
        rem_d = rem_next;
        n_d   = n_next;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CntW - 1)) begin
          acc_d   = rem_next;
          days_d  = n_next[CntW-1] ? '1 : n_next[HoursW-1:0];
          state_d = ST_STEP;
        end
      end

      ST_LEAP_MUL: begin
        q100_d  = yprod[26:19];
        state_d = ST_LEAP_CHK;
      end

      ST_LEAP_CHK: begin
        leap_d  = (year_q[1:0] == 2'b00) && ((q100_x100 != year_q) || (q100_q[1:0] == 2'b00));
        state_d = restart_q ? ST_FIX : ST_STEP;
      end

      // overlong start day: park on the month's last day, roll the excess through STEP
      ST_FIX: begin
        restart_d = 1'b0;
        if (day_q > len) begin
          n_d   = CntW'(day_q - len);
          day_d = len;
        end
        state_d = ST_STEP;
      end

      // one month per cycle unless a year is crossed; n <= left exactly when the subtractor borrows
      ST_STEP: begin
        if (sub_borrow) begin
          day_d   = day_q + n_q[DayW-1:0];
          state_d = ST_DONE;
        end else begin
          n_d   = sub_diff[CntW-1:0];
          day_d = DayW'(1);
          if (mon_q >= MonDec) begin
            mon_d = MonW'(1);
            if (year_q >= MaxYear) begin
              day_d   = DayLast;
              mon_d   = MonDec;
              year_d  = MaxYear;
              ovf_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              year_d  = year_q + YearW'(1);
              state_d = ST_LEAP_MUL;
            end
          end else begin
            mon_d = mon_q + MonW'(1);
          end
        end
      end

      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      day_q       <= DayW'(1);
      mon_q       <= MonW'(1);
      year_q      <= YearW'(2000);
      acc_q       <= '0;
      leap_q      <= 1'b1;
      restart_q   <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      day_q       <= day_d;
      mon_q       <= mon_d;
      year_q      <= year_d;
      acc_q       <= acc_d;
      leap_q      <= leap_d;
      restart_q   <= restart_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    q100_q <= q100_d;
    days_q <= days_d;
    if (out_load) begin
      out_day_q  <= day_q;
      out_mon_q  <= mon_q;
      out_year_q <= year_q;
      out_rem_q  <= acc_q;
      out_days_q <= days_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign day_o            = out_day_q;
  assign month_o          = out_mon_q;
  assign year_o           = out_year_q;
  assign hour_remainder_o = out_rem_q;
  assign days_added_o     = out_days_q;
  assign overflow_o       = out_ovf_q;

`ifndef ASSERT_OFF
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (year_q <= MaxYear) && (year_q != '0))
    else $error("calendar year out of range");

  a_day_fits_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> ((day_q != '0) && (day_q <= len)))
    else $error("day beyond month length at completion");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ovf_q) |=> ((day_o == DayLast) && (month_o == MonDec) && (year_o == MaxYear)))
    else $error("overflow without saturated date");

  a_rem_below_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && (cnt_q == 5'(CntW - 1))) |=> (acc_q < divisor))
    else $error("hour remainder not below day length");
`endif

endmodule

// ===== dv/hcda_date_monitor.sv =====
`timescale 1ns / 1ps
// Watches the config, input and result channels of the hour-to-date advancer, keeps its own
// calendar, and checks every result beat in order. Depends on hdl/hcda_pkg.sv.
module hcda_date_monitor
  import hcda_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                opcode_i,
  input  logic [HoursW-1:0]   hours_i,

  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [DayW-1:0]     day_i,
  input  logic [MonW-1:0]     month_i,
  input  logic [YearW-1:0]    year_i,
  input  logic [HpdW-1:0]     hour_remainder_i,
  input  logic [HoursW-1:0]   days_added_i,
  input  logic                overflow_i,

  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  localparam int unsigned TopYear   = 9999;
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonW-1:0]   month;
    logic [YearW-1:0]  year;
    logic [HpdW-1:0]   rem;
    logic [HoursW-1:0] days;
    logic              ovf;
  } cal_result_t;

  // register copies
  logic [HpdW-1:0]  day_hours;
  logic [DayW-1:0]  load_day;
  logic [MonW-1:0]  load_month;
  logic [YearW-1:0] load_year;

  // calendar held by the block
  logic [DayW-1:0]  cal_day;
  logic [MonW-1:0]  cal_month;
  logic [YearW-1:0] cal_year;
  logic [HpdW-1:0]  held_hours;

  cal_result_t expected_dates[$];

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      2:           len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // Walks the calendar forward month by month; 1 when it pins at 31.12.9999.
  function automatic bit roll_days(input int unsigned n);
    int unsigned len;
    int unsigned left;
    while (n > 0) begin
      len  = days_in_month(cal_month, cal_year);
      left = (cal_day < len) ? len - cal_day : 0;
      if (n <= left) begin
        cal_day = DayW'(cal_day + n);
        return 1'b0;
      end
      n -= left + 1;
      cal_day = DayW'(1);
      if (cal_month >= 12) begin
        cal_month = MonW'(1);
        if (cal_year >= TopYear) begin
          cal_day   = DayW'(31);
          cal_month = MonW'(12);
          cal_year  = YearW'(TopYear);
          return 1'b1;
        end
        cal_year = cal_year + 1'b1;
      end else begin
        cal_month = cal_month + 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic cal_result_t predict_date(input hcda_op_e op, input logic [HoursW-1:0] hrs);
    cal_result_t r;
    int unsigned d, m, y, len, div, total, whole;
    bit ovf;
    ovf   = 1'b0;
    whole = 0;
    if (op == OP_RESTART) begin
      d = (load_day == 0) ? 1 : load_day;
      m = (load_month == 0) ? 1 : ((load_month > 12) ? 12 : load_month);
      y = (load_year == 0) ? 1 : load_year;
      held_hours = '0;
      if (y > TopYear) begin
        cal_day   = DayW'(31);
        cal_month = MonW'(12);
        cal_year  = YearW'(TopYear);
        ovf       = 1'b1;
      end else begin
        len       = days_in_month(m, y);
        cal_month = MonW'(m);
        cal_year  = YearW'(y);
        if (d <= len) begin
          cal_day = DayW'(d);
        end else begin
          // overlong start day spills into the following months
          cal_day = DayW'(len);
          ovf     = roll_days(d - len);
        end
      end
    end else begin
      div        = (day_hours == 0) ? 1 : day_hours;
      total      = 32'(held_hours) + 32'(hrs);
      whole      = total / div;
      held_hours = HpdW'(total % div);
      if (whole > 0) ovf = roll_days(whole);
    end
    r.day   = cal_day;
    r.month = cal_month;
    r.year  = cal_year;
    r.rem   = held_hours;
    r.days  = (whole > 32'hFFFF) ? '1 : HoursW'(whole);
    r.ovf   = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cal_result_t seen;
    cal_result_t want;
    if (!rst_ni) begin
      day_hours    = HpdW'(24);
      load_day     = DayW'(1);
      load_month   = MonW'(1);
      load_year    = YearW'(2000);
      cal_day      = DayW'(1);
      cal_month    = MonW'(1);
      cal_year     = YearW'(2000);
      held_hours   = '0;
      expected_dates.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (hcda_cfg_e'(cfg_index_i))
          CFG_HOURS_PER_DAY: day_hours  = cfg_data_i[HpdW-1:0];
          CFG_START_DAY:     load_day   = cfg_data_i[DayW-1:0];
          CFG_START_MONTH:   load_month = cfg_data_i[MonW-1:0];
          CFG_START_YEAR:    load_year  = cfg_data_i[YearW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        seen.day   = day_i;
        seen.month = month_i;
        seen.year  = year_i;
        seen.rem   = hour_remainder_i;
        seen.days  = days_added_i;
        seen.ovf   = overflow_i;
        if (expected_dates.size() == 0) begin
          if (mismatches_o < ReportMax)
            $display("%t: result beat with none expected: %0d.%0d.%0d rem %0d days %0d ovf %0b",
                     $realtime, seen.day, seen.month, seen.year, seen.rem, seen.days, seen.ovf);
          mismatches_o++;
        end else begin
          want = expected_dates.pop_front();
          if (seen.day !== want.day || seen.month !== want.month || seen.year !== want.year ||
              seen.rem !== want.rem || seen.days !== want.days || seen.ovf !== want.ovf) begin
            if (mismatches_o < ReportMax) begin
              $display("%t: date mismatch, expected %0d.%0d.%0d rem %0d days %0d ovf %0b",
                       $realtime, want.day, want.month, want.year, want.rem, want.days, want.ovf);
              $display("%t:                actual %0d.%0d.%0d rem %0d days %0d ovf %0b",
                       $realtime, seen.day, seen.month, seen.year, seen.rem, seen.days, seen.ovf);
            end
            mismatches_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i)
        expected_dates.push_back(predict_date(hcda_op_e'(opcode_i), hours_i));

      pending_o = expected_dates.size();
    end
  end

endmodule

// ===== dv/tb_hour_to_calendar_date_advancer_core.sv =====
`timescale 1ns / 1ps
// Top of the hour-to-date advancer bench: clock, reset, stimulus phases and the verdict.
// Depends on hdl/hcda_pkg.sv, the core, and dv/hcda_date_monitor.sv for all checking.
module tb_hour_to_calendar_date_advancer_core;
  import hcda_pkg::*;

  localparam int unsigned CycleLimit    = 12_000_000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 3000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OP_RESTART;
  logic [HoursW-1:0]   hours = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DayW-1:0]     day;
  logic [MonW-1:0]     month;
  logic [YearW-1:0]    year;
  logic [HpdW-1:0]     hour_rem;
  logic [HoursW-1:0]   days_added;
  logic                overflow;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CFG_HOURS_PER_DAY;
  logic [CfgDataW-1:0] cfg_data = '0;

  int unsigned         mismatch_count;
  int unsigned         pending_dates;

  int unsigned         tx_idle_pct = 0;
  int unsigned         rx_stall_pct = 0;
  int unsigned         holds_asked = 0;

  hour_to_calendar_date_advancer_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (opcode),
    .hours_i          (hours),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .day_o            (day),
    .month_o          (month),
    .year_o           (year),
    .hour_remainder_o (hour_rem),
    .days_added_o     (days_added),
    .overflow_o       (overflow),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  hcda_date_monitor u_date_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .opcode_i         (opcode),
    .hours_i          (hours),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .day_i            (day),
    .month_i          (month),
    .year_i           (year),
    .hour_remainder_i (hour_rem),
    .days_added_i     (days_added),
    .overflow_i       (overflow),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatch_count),
    .pending_o        (pending_dates)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin : result_sink
    int unsigned holds_served;
    int unsigned hold_cnt;
    holds_served = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HoldOffCycles; hold_cnt++) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Entered and left at a falling edge; valid stays up between back-to-back beats.
  task automatic offer_item(input hcda_op_e op, input logic [HoursW-1:0] hrs);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    hours    <= hrs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every result, then switch idling modes between edges.
  task automatic quiesce(input int unsigned tx, input int unsigned rx, input bit squeeze);
    in_valid <= 1'b0;
    while (pending_dates != 0) @(negedge clk);
    @(posedge clk);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    if (squeeze) holds_asked++;
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [CfgDataW-1:0] hpd, input logic [CfgDataW-1:0] sd,
                              input logic [CfgDataW-1:0] sm, input logic [CfgDataW-1:0] sy);
    hcda_cfg_e           regs[4] = '{CFG_HOURS_PER_DAY, CFG_START_DAY, CFG_START_MONTH,
                                     CFG_START_YEAR};
    logic [CfgDataW-1:0] vals[4];
    vals = '{hpd, sd, sm, sy};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned tx,
                           input int unsigned rx, input bit squeeze,
                           input logic [CfgDataW-1:0] hpd, input logic [CfgDataW-1:0] sd,
                           input logic [CfgDataW-1:0] sm, input logic [CfgDataW-1:0] sy,
                           input int unsigned hour_span);
    hcda_op_e          op;
    logic [HoursW-1:0] hrs;
    quiesce(tx, rx, squeeze);
    load_setting(hpd, sd, sm, sy);
    for (int n = 0; n < items; n++) begin
      op = ($urandom_range(0, 7) == 0) ? OP_RESTART : OP_ADVANCE;
      case ($urandom_range(0, 7))
        0:       hrs = '1;
        1:       hrs = '0;
        2, 3:    hrs = HoursW'($urandom);
        default: hrs = HoursW'($urandom_range(0, hour_span));
      endcase
      offer_item(op, hrs);
    end
  endtask

  task automatic run_directed();
    // reset setting: 24 h day, 01.01.2000
    offer_item(OP_ADVANCE, '0);
    offer_item(OP_ADVANCE, HoursW'(23));
    offer_item(OP_ADVANCE, HoursW'(1));
    offer_item(OP_ADVANCE, '1);
    offer_item(OP_RESTART, '1);
    // 31 Feb in a leap year, then park a near-full remainder
    quiesce(0, 0, 1'b0);
    load_setting(CfgDataW'(4095), CfgDataW'(31), CfgDataW'(2), CfgDataW'(2000));
    offer_item(OP_RESTART, '0);
    offer_item(OP_ADVANCE, HoursW'(4094));
    // shrink the day to one hour: whole-day count goes past 16 bits
    quiesce(0, 0, 1'b0);
    load_setting(CfgDataW'(1), CfgDataW'(31), CfgDataW'(2), CfgDataW'(2000));
    offer_item(OP_ADVANCE, '1);
    // zero everywhere: day length one, 01.01.0001
    quiesce(0, 0, 1'b0);
    load_setting('0, '0, '0, '0);
    offer_item(OP_RESTART, '0);
    offer_item(OP_ADVANCE, '0);
    offer_item(OP_ADVANCE, HoursW'(1));
    // year beyond 9999 on restart, then saturation on advance
    quiesce(0, 0, 1'b0);
    load_setting(CfgDataW'(7), CfgDataW'(31), CfgDataW'(15), CfgDataW'(16383));
    offer_item(OP_RESTART, '0);
    offer_item(OP_ADVANCE, HoursW'(10));
    // last day of 9999 reached legally; the held remainder carries into the saturating advance
    quiesce(0, 0, 1'b0);
    load_setting(CfgDataW'(7), CfgDataW'(31), CfgDataW'(13), CfgDataW'(9999));
    offer_item(OP_RESTART, '0);
    offer_item(OP_ADVANCE, HoursW'(6));
    offer_item(OP_ADVANCE, HoursW'(8));
    // century that is not a leap year, then an overlong April day and 29 Feb of a leap year
    quiesce(0, 0, 1'b0);
    load_setting(CfgDataW'(24), CfgDataW'(30), CfgDataW'(2), CfgDataW'(1900));
    offer_item(OP_RESTART, '0);
    quiesce(0, 0, 1'b0);
    load_setting(CfgDataW'(24), CfgDataW'(31), CfgDataW'(4), CfgDataW'(2023));
    offer_item(OP_RESTART, '0);
    quiesce(0, 0, 1'b0);
    load_setting(CfgDataW'(24), CfgDataW'(29), CfgDataW'(2), CfgDataW'(2024));
    offer_item(OP_RESTART, '0);
    offer_item(OP_ADVANCE, HoursW'(24));
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    run_phase(250, 0, 0, 1'b0, CfgDataW'(24), CfgDataW'(29), CfgDataW'(2), CfgDataW'(2000),
              65535);
    run_phase(200, 55, 0, 1'b0, CfgDataW'(4095), CfgDataW'(31), CfgDataW'(12),
              CfgDataW'(1999), 65535);
    run_phase(60, 0, 55, 1'b0, CfgDataW'(1), CfgDataW'(1), CfgDataW'(1), CfgDataW'(1), 400);
    run_phase(60, 31, 31, 1'b0, '0, CfgDataW'(28), CfgDataW'(2), CfgDataW'(9990), 2000);
    // receiver holds off while beats keep coming, so the core backs up
    run_phase(150, 0, 0, 1'b1, CfgDataW'(24), CfgDataW'(15), CfgDataW'(6), CfgDataW'(2023),
              200);
    // random settings, upper data bits included; day length kept off the slow end
    run_phase(200, 31, 31, 1'b0,
              CfgDataW'($urandom_range(8, 4095) | ($urandom_range(0, 3) << HpdW)),
              CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom_range(0, 16383)),
              65535);
    run_phase(180, 0, 55, 1'b0,
              CfgDataW'($urandom_range(8, 4095) | ($urandom_range(0, 3) << HpdW)),
              CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom_range(9900, 9999)),
              65535);

    quiesce(0, 0, 1'b0);
    repeat (SettleCycles) @(negedge clk);
    if (mismatch_count == 0 && pending_dates == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hcda_pkg.sv
hdl/hour_to_calendar_date_advancer_core.sv
dv/hcda_date_monitor.sv
dv/tb_hour_to_calendar_date_advancer_core.sv
